>>> rtl/icd_pkg.sv
// Shared constants, codes and control structs for the interval cover depth tree.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package icd_pkg;

  localparam int LEAVES      = 1024;
  localparam int COUNT_BITS  = 16;
  localparam int NODES       = 4 * LEAVES;
  localparam int COORDS      = LEAVES + 2;
  localparam int NODE_AW     = $clog2(NODES);
  localparam int COORD_AW    = $clog2(COORDS);
  localparam int LEAF_W      = 11;
  localparam int LEN_W       = 32;
  localparam int NODE_W      = COUNT_BITS + 3 * LEN_W;
  localparam int STACK_DEPTH = $clog2(LEAVES) + 2;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SIDX_W      = $clog2(STACK_DEPTH);

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_APPLY = 2'd2;

  localparam logic [1:0] PH_ENTER = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;

  typedef struct packed {
    logic take;
    logic clr_wr;
    logic coord_wr;
    logic walk_init;
    logic walk_step;
    logic walk_pop;
    logic rc0;
    logic rc1;
    logic rc2;
    logic rc3;
    logic root_rd;
    logic out_load;
  } icd_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       range_ok;
    logic       top_rc;
    logic       top_oob;
    logic       stack_last;
    logic       out_busy;
  } icd_sts_t;

endpackage

>>> rtl/interval_cover_depth_tree.sv
// Top level of the interval cover depth tree: controller plus datapath.
// Depends on icd_pkg, icd_ctrl, icd_dp (and through it icd_ram).
`timescale 1ns / 1ps

// This block keeps a segment tree over up to 1024 leaves between compressed
// coordinates and reports, after every input word, how much length is covered
// at least once, twice and three times. A clear word zeroes every node with a
// sweep of the node memory, one node per cycle; the same sweep runs after
// reset, and no word is accepted until it is done (the configuration port is
// always open). A load word writes one coordinate entry (an index past the last
// entry writes nothing); its result is read from the root node, and the input
// opens again in the same cycle that this result becomes valid. An apply word
// walks the tree with a small stack: each visited node costs one to three
// controller steps and a recompute through the single read port of the node
// memory. Only one word is in work at a time; a finished result waits in the
// output register, and the next word's result is held back only while that
// register is full. Coordinate entries read before they were written give
// meaningless lengths.
module interval_cover_depth_tree (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [icd_pkg::LEAF_W-1:0]       cfg_leaf_count,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_opcode,
  input  logic [icd_pkg::LEAF_W-1:0]       in_coord_index,
  input  logic signed [icd_pkg::LEN_W-1:0] in_coord_value,
  input  logic [icd_pkg::LEAF_W-1:0]       in_range_low,
  input  logic [icd_pkg::LEAF_W-1:0]       in_range_high,
  input  logic signed [1:0]                in_delta,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [icd_pkg::LEN_W-1:0]        out_len_once,
  output logic [icd_pkg::LEN_W-1:0]        out_len_twice,
  output logic [icd_pkg::LEN_W-1:0]        out_len_thrice
);

  // Commands flow from the controller; status flows back from the datapath.
  icd_pkg::icd_cmd_t cmd;
  icd_pkg::icd_sts_t sts;

  icd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  icd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_leaf_count (cfg_leaf_count),
    .in_opcode      (in_opcode),
    .in_coord_index (in_coord_index),
    .in_coord_value (in_coord_value),
    .in_range_low   (in_range_low),
    .in_range_high  (in_range_high),
    .in_delta       (in_delta),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_len_once   (out_len_once),
    .out_len_twice  (out_len_twice),
    .out_len_thrice (out_len_thrice)
  );

endmodule

>>> rtl/icd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module icd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/icd_ctrl.sv
// Controller state machine for the interval cover depth tree.
// Depends on icd_pkg; drives the datapath through icd_cmd_t and reads icd_sts_t.
`timescale 1ns / 1ps

module icd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  icd_pkg::icd_sts_t sts,
  output icd_pkg::icd_cmd_t cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_WK   = 4'd3;
  localparam logic [3:0] S_RC0  = 4'd4;
  localparam logic [3:0] S_RC1  = 4'd5;
  localparam logic [3:0] S_RC2  = 4'd6;
  localparam logic [3:0] S_RC3  = 4'd7;
  localparam logic [3:0] S_RT0  = 4'd8;
  localparam logic [3:0] S_RT1  = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    cmd       = '0;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = pend_r ? S_RT0 : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.op == icd_pkg::OP_CLEAR) begin
          pend_nxt  = 1'b1;
          state_nxt = S_CLR;
        end else if (sts.op == icd_pkg::OP_LOAD) begin
          cmd.coord_wr = 1'b1;
          state_nxt    = S_RT0;
        end else if (sts.op == icd_pkg::OP_APPLY && sts.range_ok) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WK;
        end else begin
          state_nxt = S_RT0;
        end
      end
      S_WK: begin
        if (sts.top_oob) begin
          cmd.walk_pop = 1'b1;
          state_nxt    = sts.stack_last ? S_RT0 : S_WK;
        end else if (sts.top_rc) begin
          state_nxt = S_RC0;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_RC0: begin
        cmd.rc0   = 1'b1;
        state_nxt = S_RC1;
      end
      S_RC1: begin
        cmd.rc1   = 1'b1;
        state_nxt = S_RC2;
      end
      S_RC2: begin
        cmd.rc2   = 1'b1;
        state_nxt = S_RC3;
      end
      S_RC3: begin
        cmd.rc3   = 1'b1;
        state_nxt = sts.stack_last ? S_RT0 : S_WK;
      end
      S_RT0: begin
        cmd.root_rd = 1'b1;
        state_nxt   = S_RT1;
      end
      S_RT1: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          pend_nxt     = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

endmodule

>>> rtl/icd_dp.sv
// Datapath of the interval cover depth tree: item registers, walk stack,
// node and coordinate memories, node recompute and output register. Depends on icd_pkg, icd_ram.
`timescale 1ns / 1ps

module icd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  icd_pkg::icd_cmd_t                   cmd,
  output icd_pkg::icd_sts_t                   sts,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [icd_pkg::LEAF_W-1:0]          cfg_leaf_count,
  input  logic [1:0]                          in_opcode,
  input  logic [icd_pkg::LEAF_W-1:0]          in_coord_index,
  input  logic signed [icd_pkg::LEN_W-1:0]    in_coord_value,
  input  logic [icd_pkg::LEAF_W-1:0]          in_range_low,
  input  logic [icd_pkg::LEAF_W-1:0]          in_range_high,
  input  logic signed [1:0]                   in_delta,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [icd_pkg::LEN_W-1:0]           out_len_once,
  output logic [icd_pkg::LEN_W-1:0]           out_len_twice,
  output logic [icd_pkg::LEN_W-1:0]           out_len_thrice
);

  localparam int LW = icd_pkg::LEAF_W;
  localparam int DW = icd_pkg::LEN_W;
  localparam int CB = icd_pkg::COUNT_BITS;
  localparam int AW = icd_pkg::NODE_AW;
  localparam int IW = icd_pkg::NODE_AW + 1;

  // Configuration register.
  logic [LW-1:0] leaf_count_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_count_r <= LW'(1);
    end else if (cfg_valid) begin
      if (cfg_leaf_count == '0) begin
        leaf_count_r <= LW'(1);
      end else if (cfg_leaf_count > LW'(icd_pkg::LEAVES)) begin
        leaf_count_r <= LW'(icd_pkg::LEAVES);
      end else begin
        leaf_count_r <= cfg_leaf_count;
      end
    end
  end

  // Item registers; the apply range is clipped as it is taken.
  logic [1:0]        op_r;
  logic [LW-1:0]     idx_r, a_r, b_r;
  logic [DW-1:0]     val_r;
  logic signed [1:0] dlt_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r  <= in_opcode;
      idx_r <= in_coord_index;
      val_r <= in_coord_value;
      dlt_r <= in_delta;
      a_r   <= (in_range_low == '0) ? LW'(1) : in_range_low;
      b_r   <= (in_range_high > leaf_count_r) ? leaf_count_r : in_range_high;
    end
  end

  // Clear sweep address.
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
  end

  // Walk stack of pending tree nodes.
  logic [icd_pkg::SP_W-1:0] sp_r;
  logic [LW-1:0]            stk_lo [icd_pkg::STACK_DEPTH];
  logic [LW-1:0]            stk_hi [icd_pkg::STACK_DEPTH];
  logic [IW-1:0]            stk_id [icd_pkg::STACK_DEPTH];
  logic [1:0]               stk_ph [icd_pkg::STACK_DEPTH];

  logic [icd_pkg::SIDX_W-1:0] tidx, pidx;
  logic [LW-1:0]              top_lo, top_hi, mid;
  logic [IW-1:0]              top_id, kid_a, kid_b;
  logic [1:0]                 top_ph;
  logic                       full, left_go, right_go, push_ok;

  assign tidx     = icd_pkg::SIDX_W'(sp_r - icd_pkg::SP_W'(1));
  assign pidx     = icd_pkg::SIDX_W'(sp_r);
  assign push_ok  = sp_r < icd_pkg::SP_W'(icd_pkg::STACK_DEPTH);
  assign top_lo   = stk_lo[tidx];
  assign top_hi   = stk_hi[tidx];
  assign top_id   = stk_id[tidx];
  assign top_ph   = stk_ph[tidx];
  assign mid      = LW'(({1'b0, top_lo} + {1'b0, top_hi}) >> 1);
  assign full     = (a_r <= top_lo) && (top_hi <= b_r);
  assign left_go  = a_r <= mid;
  assign right_go = b_r > mid;
  assign kid_a    = {top_id[AW-1:0], 1'b0};
  assign kid_b    = {top_id[AW-1:0], 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.walk_init) begin
      sp_r <= icd_pkg::SP_W'(1);
    end else if (cmd.walk_pop || cmd.rc3) begin
      sp_r <= sp_r - icd_pkg::SP_W'(1);
    end else if (cmd.walk_step && push_ok &&
                 ((top_ph == icd_pkg::PH_ENTER && left_go) ||
                  (top_ph == icd_pkg::PH_LEFT && right_go))) begin
      sp_r <= sp_r + icd_pkg::SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      stk_lo[0] <= LW'(1);
      stk_hi[0] <= leaf_count_r;
      stk_id[0] <= IW'(1);
      stk_ph[0] <= icd_pkg::PH_ENTER;
    end else if (cmd.walk_step) begin
      if (top_ph == icd_pkg::PH_ENTER) begin
        stk_ph[tidx] <= icd_pkg::PH_LEFT;
        if (left_go && push_ok) begin
          stk_lo[pidx] <= top_lo;
          stk_hi[pidx] <= mid;
          stk_id[pidx] <= kid_a;
          stk_ph[pidx] <= icd_pkg::PH_ENTER;
        end
      end else begin
        stk_ph[tidx] <= icd_pkg::PH_RIGHT;
        if (right_go && push_ok) begin
          stk_lo[pidx] <= mid + LW'(1);
          stk_hi[pidx] <= top_hi;
          stk_id[pidx] <= kid_b;
          stk_ph[pidx] <= icd_pkg::PH_ENTER;
        end
      end
    end
  end

  // Node memory: {count, once, twice, thrice}.
  logic                      node_we, node_re;
  logic [AW-1:0]             node_waddr, node_raddr;
  logic [icd_pkg::NODE_W-1:0] node_wdata, node_rdata;

  // Coordinate memory.
  logic                          crd_we, crd_re;
  logic [icd_pkg::COORD_AW-1:0]  crd_raddr;
  logic [DW-1:0]                 crd_rdata;

  assign crd_we    = cmd.coord_wr && (idx_r < LW'(icd_pkg::COORDS));
  assign crd_re    = cmd.rc0 || cmd.rc1;
  assign crd_raddr = cmd.rc0 ? icd_pkg::COORD_AW'(top_lo)
                             : icd_pkg::COORD_AW'(top_hi + LW'(1));

  icd_ram #(.WIDTH(DW), .DEPTH(icd_pkg::COORDS)) u_coord_ram (
    .clk     (clk),
    .wr_en   (crd_we),
    .wr_addr (icd_pkg::COORD_AW'(idx_r)),
    .wr_data (val_r),
    .rd_en   (crd_re),
    .rd_addr (crd_raddr),
    .rd_data (crd_rdata)
  );

  icd_ram #(.WIDTH(icd_pkg::NODE_W), .DEPTH(icd_pkg::NODES)) u_node_ram (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (node_waddr),
    .wr_data (node_wdata),
    .rd_en   (node_re),
    .rd_addr (node_raddr),
    .rd_data (node_rdata)
  );

  // Recompute: the node and coordinate reads issued in steps rc0 to rc2 land in rc1, rc2 and rc3.
  logic [CB-1:0] cnt_r;
  logic [DW-1:0] clo_r, chi_r, ka1_r, ka2_r, ka3_r;

  always_ff @(posedge clk) begin
    if (cmd.rc1) begin
      cnt_r <= node_rdata[icd_pkg::NODE_W-1 -: CB];
      clo_r <= crd_rdata;
    end
    if (cmd.rc2) begin
      ka1_r <= node_rdata[3*DW-1 -: DW];
      ka2_r <= node_rdata[2*DW-1 -: DW];
      ka3_r <= node_rdata[DW-1:0];
      chi_r <= crd_rdata;
    end
  end

  logic              kids;
  logic signed [CB+1:0] cnt_sum;
  logic [CB-1:0]     cnt_new;
  logic [DW-1:0]     span, o1, o2, o3, n1, n2, n3;

  assign kids    = (top_lo != top_hi) && (top_id < IW'(icd_pkg::NODES / 2));
  assign cnt_sum = $signed({2'b00, cnt_r}) + $signed({{CB{dlt_r[1]}}, dlt_r});
  assign span    = chi_r - clo_r;
  assign o1      = kids ? ka1_r + node_rdata[3*DW-1 -: DW] : '0;
  assign o2      = kids ? ka2_r + node_rdata[2*DW-1 -: DW] : '0;
  assign o3      = kids ? ka3_r + node_rdata[DW-1:0] : '0;

  always_comb begin
    if (top_ph != icd_pkg::PH_ENTER) begin
      cnt_new = cnt_r;
    end else if (cnt_sum < 0) begin
      cnt_new = '0;
    end else if (cnt_sum[CB+1:CB] != 2'b00) begin
      cnt_new = '1;
    end else begin
      cnt_new = cnt_sum[CB-1:0];
    end
    n1 = (cnt_new >= CB'(1)) ? span : o1;
    n2 = (cnt_new >= CB'(2)) ? span : (cnt_new == CB'(1)) ? o1 : o2;
    n3 = (cnt_new >= CB'(3)) ? span : (cnt_new == CB'(2)) ? o1
       : (cnt_new == CB'(1)) ? o2 : o3;
  end

  assign node_we    = cmd.clr_wr || cmd.rc3;
  assign node_waddr = cmd.clr_wr ? clr_addr_r : top_id[AW-1:0];
  assign node_wdata = cmd.clr_wr ? '0 : {cnt_new, n1, n2, n3};
  assign node_re    = cmd.rc0 || cmd.rc1 || cmd.rc2 || cmd.root_rd;

  always_comb begin
    if (cmd.rc0) begin
      node_raddr = top_id[AW-1:0];
    end else if (cmd.rc1) begin
      node_raddr = kid_a[AW-1:0];
    end else if (cmd.rc2) begin
      node_raddr = kid_b[AW-1:0];
    end else begin
      node_raddr = AW'(1);
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_len_once   <= node_rdata[3*DW-1 -: DW];
      out_len_twice  <= node_rdata[2*DW-1 -: DW];
      out_len_thrice <= node_rdata[DW-1:0];
    end
  end

  assign out_valid = out_valid_r;

  assign sts.clr_last   = clr_addr_r == AW'(icd_pkg::NODES - 1);
  assign sts.op         = op_r;
  assign sts.range_ok   = a_r <= b_r;
  assign sts.top_rc     = (top_ph == icd_pkg::PH_ENTER && full) ||
                          (top_ph == icd_pkg::PH_RIGHT);
  assign sts.top_oob    = top_id >= IW'(icd_pkg::NODES);
  assign sts.stack_last = sp_r == icd_pkg::SP_W'(1);
  assign sts.out_busy   = out_valid_r && !out_ready;

endmodule

>>> rtl/icd_checker.sv
// Port-level checks for the interval cover depth tree, bound to the top level.
// Depends on icd_pkg and interval_cover_depth_tree.
`timescale 1ns / 1ps

module icd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [icd_pkg::LEN_W-1:0]  out_len_once
);

  // A held result stays valid and keeps its once length until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_len_once))
    else $error("result word changed while stalled");

  // One word at a time: the input closes right after an accept.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while one is in work");

  // Reset leaves no result pending.
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The clearing sweep after reset keeps the input closed.
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during the clearing sweep");

endmodule

bind interval_cover_depth_tree icd_checker u_icd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_len_once (out_len_once)
);

>>> verif/tb_interval_cover_depth_tree.sv
// Self-checking testbench for interval_cover_depth_tree: random handshake timing on the
// input and output channels, checked word by word against a behavioral copy of the tree.
// Depends on icd_pkg and the interval_cover_depth_tree RTL only.
`timescale 1ns / 1ps

module tb_interval_cover_depth_tree;

  // Opcode 3 is unused by the block and must leave the tree alone.
  localparam logic [1:0] OP_IDLE = 2'd3;
  localparam int unsigned COUNT_SAT = (1 << icd_pkg::COUNT_BITS) - 1;

  typedef struct {
    logic [1:0]                 opcode;
    logic [icd_pkg::LEAF_W-1:0] coord_index;
    logic [icd_pkg::LEN_W-1:0]  coord_value;
    logic [icd_pkg::LEAF_W-1:0] range_low;
    logic [icd_pkg::LEAF_W-1:0] range_high;
    logic [1:0]                 delta;
  } cmd_word_t;

  typedef struct {
    logic [icd_pkg::LEN_W-1:0] once;
    logic [icd_pkg::LEN_W-1:0] twice;
    logic [icd_pkg::LEN_W-1:0] thrice;
  } cover_lens_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [icd_pkg::LEAF_W-1:0] cfg_leaf_count = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_opcode = '0;
  logic [icd_pkg::LEAF_W-1:0] in_coord_index = '0;
  logic signed [icd_pkg::LEN_W-1:0] in_coord_value = '0;
  logic [icd_pkg::LEAF_W-1:0] in_range_low = '0;
  logic [icd_pkg::LEAF_W-1:0] in_range_high = '0;
  logic signed [1:0] in_delta = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [icd_pkg::LEN_W-1:0] out_len_once;
  logic [icd_pkg::LEN_W-1:0] out_len_twice;
  logic [icd_pkg::LEN_W-1:0] out_len_thrice;

  interval_cover_depth_tree u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_leaf_count (cfg_leaf_count),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_coord_index (in_coord_index),
    .in_coord_value (in_coord_value),
    .in_range_low   (in_range_low),
    .in_range_high  (in_range_high),
    .in_delta       (in_delta),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_len_once   (out_len_once),
    .out_len_twice  (out_len_twice),
    .out_len_thrice (out_len_thrice)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting for the driver, and root lengths waiting for the monitor.
  cmd_word_t   word_queue[$];
  cover_lens_t root_len_queue[$];
  int          error_count = 0;
  // When set, both sides draw their idle cycles; when clear they run back to back.
  bit          idle_on = 1'b1;

  // Behavioral copy of the tree. The sizes follow the package.
  int unsigned               tree_leaves = 1;
  logic [icd_pkg::LEN_W-1:0] coord_mem[icd_pkg::COORDS];
  int unsigned               count_mem[icd_pkg::NODES];
  logic [icd_pkg::LEN_W-1:0] once_mem[icd_pkg::NODES];
  logic [icd_pkg::LEN_W-1:0] twice_mem[icd_pkg::NODES];
  logic [icd_pkg::LEN_W-1:0] thrice_mem[icd_pkg::NODES];

  function automatic logic [icd_pkg::LEN_W-1:0] coord_of(int unsigned i);
    return (i < icd_pkg::COORDS) ? coord_mem[i] : '0;
  endfunction

  function automatic void clear_nodes();
    for (int i = 0; i < icd_pkg::NODES; i++) begin
      count_mem[i] = 0;
      once_mem[i] = '0;
      twice_mem[i] = '0;
      thrice_mem[i] = '0;
    end
  endfunction

  // Rebuilds one node's three lengths from its own count and its children.
  function automatic void refresh_node(int unsigned lo, int unsigned hi, int unsigned id);
    int unsigned c;
    logic [icd_pkg::LEN_W-1:0] span, s1, s2, s3;
    bit leaf;
    c = count_mem[id];
    span = coord_of(hi + 1) - coord_of(lo);
    leaf = (lo == hi);
    s1 = '0;
    s2 = '0;
    s3 = '0;
    if (!leaf && (2 * id + 1) < icd_pkg::NODES) begin
      s1 = once_mem[2*id] + once_mem[2*id+1];
      s2 = twice_mem[2*id] + twice_mem[2*id+1];
      s3 = thrice_mem[2*id] + thrice_mem[2*id+1];
    end
    once_mem[id] = (c >= 1) ? span : leaf ? '0 : s1;
    twice_mem[id] = (c >= 2) ? span : leaf ? '0 : (c == 1) ? s1 : s2;
    thrice_mem[id] = (c >= 3) ? span : leaf ? '0 : (c == 2) ? s1 : (c == 1) ? s2 : s3;
  endfunction

  // Adds the delta to the canonical nodes of [a, b] and refreshes the path bottom-up.
  function automatic void add_cover(int unsigned lo, int unsigned hi, int unsigned a,
                                    int unsigned b, int d, int unsigned id);
    int unsigned mid;
    int n;
    if (id >= icd_pkg::NODES) return;
    if (a <= lo && hi <= b) begin
      n = int'(count_mem[id]) + d;
      if (n < 0) n = 0;
      if (n > int'(COUNT_SAT)) n = int'(COUNT_SAT);
      count_mem[id] = unsigned'(n);
      refresh_node(lo, hi, id);
      return;
    end
    mid = (lo + hi) >> 1;
    if (a <= mid) add_cover(lo, mid, a, b, d, 2 * id);
    if (b > mid) add_cover(mid + 1, hi, a, b, d, 2 * id + 1);
    refresh_node(lo, hi, id);
  endfunction

  // Applies one accepted word to the copy and returns the root lengths it reports.
  function automatic cover_lens_t predict_root(cmd_word_t w);
    cover_lens_t r;
    int unsigned a, b;
    case (w.opcode)
      icd_pkg::OP_CLEAR: clear_nodes();
      icd_pkg::OP_LOAD: begin
        if (w.coord_index < icd_pkg::COORDS) coord_mem[w.coord_index] = w.coord_value;
      end
      icd_pkg::OP_APPLY: begin
        a = (w.range_low < 1) ? 1 : w.range_low;
        b = (w.range_high > tree_leaves) ? tree_leaves : w.range_high;
        if (a <= b) add_cover(1, tree_leaves, a, b, $signed(w.delta), 1);
      end
      default: ;
    endcase
    r.once = once_mem[1];
    r.twice = twice_mem[1];
    r.thrice = thrice_mem[1];
    return r;
  endfunction

  // Driver: holds each word until it is taken, then waits its drawn idle cycles.
  cmd_word_t drv_word;
  int        drv_gap = 0;

  always @(posedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        root_len_queue.push_back(predict_root(drv_word));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (word_queue.size() > 0) begin
          drv_word = word_queue.pop_front();
          in_opcode <= drv_word.opcode;
          in_coord_index <= drv_word.coord_index;
          in_coord_value <= drv_word.coord_value;
          in_range_low <= drv_word.range_low;
          in_range_high <= drv_word.range_high;
          in_delta <= drv_word.delta;
          next_valid = 1'b1;
          drv_gap = idle_on ? $urandom_range(0, 16) : 0;
        end
      end
    end
    in_valid <= next_valid;
  end

  // Monitor: compares each taken result word with the oldest prediction and
  // then stalls for its own drawn number of cycles.
  int mon_stall = 0;

  always @(posedge clk) begin
    cover_lens_t exp_r;
    logic next_ready;
    next_ready = out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (root_len_queue.size() == 0) begin
          $error("result word with no prediction waiting");
          error_count++;
        end else begin
          exp_r = root_len_queue.pop_front();
          if (out_len_once !== exp_r.once) begin
            $error("len_once: expected %0d, got %0d", exp_r.once, out_len_once);
            error_count++;
          end
          if (out_len_twice !== exp_r.twice) begin
            $error("len_twice: expected %0d, got %0d", exp_r.twice, out_len_twice);
            error_count++;
          end
          if (out_len_thrice !== exp_r.thrice) begin
            $error("len_thrice: expected %0d, got %0d", exp_r.thrice, out_len_thrice);
            error_count++;
          end
        end
        mon_stall = idle_on ? $urandom_range(0, 16) : 0;
      end
      if (mon_stall > 0) begin
        mon_stall--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
    end
    out_ready <= next_ready;
  end

  function automatic cmd_word_t mk_word(logic [1:0] op, int unsigned idx, logic [31:0] val,
                                        int unsigned lo, int unsigned hi, int unsigned d);
    cmd_word_t w;
    w.opcode = op;
    w.coord_index = icd_pkg::LEAF_W'(idx);
    w.coord_value = val;
    w.range_low = icd_pkg::LEAF_W'(lo);
    w.range_high = icd_pkg::LEAF_W'(hi);
    w.delta = 2'(d);
    return w;
  endfunction

  // Blocks until the driver has drained and every prediction is matched, plus a
  // margin so nothing is still in flight inside the block.
  task automatic wait_drained();
    do @(posedge clk); while (word_queue.size() > 0 || in_valid || root_len_queue.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_leaf_count(int unsigned v);
    logic [icd_pkg::LEAF_W-1:0] vb;
    int unsigned lc;
    vb = icd_pkg::LEAF_W'(v);
    wait_drained();
    cfg_leaf_count <= vb;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    lc = (vb < 1) ? 1 : (vb > icd_pkg::LEAVES) ? icd_pkg::LEAVES : vb;
    tree_leaves = lc;
  endtask

  // Random traffic for one leaf count. Most words open an interval and later
  // close the same one, so the counts climb past one, two and three; the rest
  // are loose ranges, odd deltas, reloads, unused opcodes and the odd clear.
  task automatic random_phase(int unsigned lc, int unsigned n_words);
    int unsigned lo, hi, k, pick;
    int unsigned open_lo[$], open_hi[$];
    for (int i = 0; i < n_words; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        lo = $urandom_range(1, lc);
        hi = $urandom_range(lo, lc);
        open_lo.push_back(lo);
        open_hi.push_back(hi);
        word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, lo, hi, 1));
      end else if (pick < 75 && open_lo.size() > 0) begin
        k = $urandom_range(0, open_lo.size() - 1);
        word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, open_lo[k], open_hi[k], 3));
        open_lo.delete(k);
        open_hi.delete(k);
      end else if (pick < 88) begin
        word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, $urandom_range(0, 2047),
                                     $urandom_range(0, 2047), $urandom_range(0, 3)));
      end else if (pick < 95) begin
        word_queue.push_back(mk_word(icd_pkg::OP_LOAD, $urandom_range(0, 2047), $urandom(),
                                     0, 0, 0));
      end else if (pick < 98) begin
        word_queue.push_back(mk_word(OP_IDLE, $urandom(), $urandom(), $urandom(), $urandom(),
                                     $urandom()));
      end else begin
        word_queue.push_back(mk_word(icd_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
        open_lo.delete();
        open_hi.delete();
      end
    end
  endtask

  initial begin
    logic [31:0] pos;
    for (int i = 0; i < icd_pkg::COORDS; i++) coord_mem[i] = '0;
    clear_nodes();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Slots 1 to LEAVES/2+1 and the last slot are loaded before any apply word,
    // in sorted order. The full tree is then driven only with the whole span or
    // with ranges inside its left half, which read no other slot.
    pos = 32'hFFF0_0000;
    for (int i = 1; i <= icd_pkg::LEAVES / 2 + 1; i++) begin
      word_queue.push_back(mk_word(icd_pkg::OP_LOAD, i, pos, 0, 0, 0));
      pos = pos + $urandom_range(0, 4000);
    end
    word_queue.push_back(mk_word(icd_pkg::OP_LOAD, icd_pkg::LEAVES + 1, pos, 0, 0, 0));

    // Directed words at the default single leaf.
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 0, 2047, 1));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, 1, 1));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, 1, 1));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, 1, 2));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, 1, 2));
    wait_drained();
    write_leaf_count(0);

    // Full tree: extremes of every field, empty and clipped ranges, deltas of
    // zero and minus two, saturation at zero, unused opcode, loads out of range.
    write_leaf_count(icd_pkg::LEAVES);
    word_queue.push_back(mk_word(icd_pkg::OP_LOAD, 0, 32'h8000_0000, 0, 0, 0));
    word_queue.push_back(mk_word(icd_pkg::OP_LOAD, 2047, 32'h7FFF_FFFF, 0, 0, 0));
    word_queue.push_back(mk_word(icd_pkg::OP_LOAD, icd_pkg::LEAVES + 2, 32'hFFFF_FFFF,
                                 0, 0, 0));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, icd_pkg::LEAVES, 1));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 0, 2047, 1));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 300, 500, 1));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, 512, 0));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 800, 100, 1));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1025, 2047, 1));
    word_queue.push_back(mk_word(OP_IDLE, 2047, 32'hFFFF_FFFF, 2047, 2047, 3));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, icd_pkg::LEAVES, 2));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, icd_pkg::LEAVES, 2));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, 1, 3));
    // A reversed pair of coordinates gives a wrapped span.
    word_queue.push_back(mk_word(icd_pkg::OP_LOAD, 10, 32'h7FFF_FFFF, 0, 0, 0));
    word_queue.push_back(mk_word(icd_pkg::OP_LOAD, 11, 32'h8000_0000, 0, 0, 0));
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 10, 10, 1));
    word_queue.push_back(mk_word(icd_pkg::OP_CLEAR, 0, 0, 0, 0, 0));

    write_leaf_count(icd_pkg::LEAVES / 2);
    random_phase(icd_pkg::LEAVES / 2, 40);
    wait_drained();
    idle_on = 1'b0;
    random_phase(icd_pkg::LEAVES / 2, 60);
    wait_drained();
    idle_on = 1'b1;
    // An oversized count is taken as the full tree; the whole span shows it.
    write_leaf_count(2047);
    word_queue.push_back(mk_word(icd_pkg::OP_APPLY, 0, 0, 1, 2047, 1));
    write_leaf_count(7);
    random_phase(7, 70);
    write_leaf_count(300);
    random_phase(300, 80);
    write_leaf_count(2);
    random_phase(2, 40);
    write_leaf_count(1);
    random_phase(1, 20);

    wait_drained();
    repeat (200) @(posedge clk);
    if (error_count == 0 && root_len_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Several times the slowest legal run, including the clears and the reset sweep.
  initial begin
    #40ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> interval_cover_depth_tree.f
rtl/icd_pkg.sv
rtl/icd_ram.sv
rtl/icd_ctrl.sv
rtl/icd_dp.sv
rtl/interval_cover_depth_tree.sv
rtl/icd_checker.sv
verif/tb_interval_cover_depth_tree.sv
